// ===== rtl/core/rhc_pkg.sv =====
// Shared types and constants for the RGB/HSV color converter.
// Used by the converter top level, its divider pipeline and the port checker.
package rhc_pkg;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t a;
		chan_t b;
		chan_t c;
	} color_t;

	// Operation codes
	localparam logic [1:0] OP_TO_HSV  = 2'd0;
	localparam logic [1:0] OP_TO_RGB  = 2'd1;
	localparam logic [1:0] OP_SET_SAT = 2'd2;

	// Hue geometry: 43-wide sectors, green and blue sectors start at 85 and 171
	localparam chan_t HUE_SECTOR = 8'd43;
	localparam chan_t HUE_BASE_G = 8'd85;
	localparam chan_t HUE_BASE_B = 8'd171;

	// Divider: 8 quotient bits, 2 per stage
	localparam int QUO_W      = 8;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEP;

	// Register stages from input transfer to output register
	localparam int PIPE_DEPTH = 9;

endpackage

// ===== rtl/core/rhc_div_pipe.sv =====
// Pipelined restoring divider, 16-bit dividend by 8-bit divisor, 8-bit quotient.
// Each stage retires STEP_BITS quotient bits; depends on rhc_pkg.
module rhc_div_pipe #(
	parameter int STEP_BITS = 2
) (
	input  logic                                   clk,
	input  logic [rhc_pkg::QUO_W/STEP_BITS-1:0]    adv,
	input  logic [2*rhc_pkg::QUO_W-1:0]            num,
	input  logic [rhc_pkg::QUO_W-1:0]              den,
	output logic [rhc_pkg::QUO_W-1:0]              quo
);

	localparam int W      = rhc_pkg::QUO_W;
	localparam int STAGES = rhc_pkg::QUO_W / STEP_BITS;

	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] low;
		logic [W-1:0] quo;
	} div_t;

	function automatic div_t div_step(div_t x, logic [W-1:0] d);
		div_t        y;
		logic [W:0]  r;
		logic        bit_q;
		y = x;
		for (int i = 0; i < STEP_BITS; i++) begin
			r     = {y.rem, y.low[W-1]};
			bit_q = (r >= {1'b0, d});
			if (bit_q) begin
				r = r - {1'b0, d};
			end
			y.rem = r[W-1:0];
			y.low = {y.low[W-2:0], 1'b0};
			y.quo = {y.quo[W-2:0], bit_q};
		end
		return y;
	endfunction

	div_t         st_q  [STAGES];
	logic [W-1:0] den_q [STAGES];

	// Dividend high half is below the divisor, so it seeds the remainder directly
	div_t init;
	assign init = '{rem: num[2*W-1:W], low: num[W-1:0], quo: '0};

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv[g]) begin
					st_q[g]  <= div_step(init, den);
					den_q[g] <= den;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv[g]) begin
					st_q[g]  <= div_step(st_q[g-1], den_q[g-1]);
					den_q[g] <= den_q[g-1];
				end
			end
		end
	end

	assign quo = st_q[STAGES-1].quo;

endmodule

// ===== rtl/core/rgb_hsv_color_converter_unit.sv =====
// Top level of the 8-bit RGB/HSV color converter: nine-stage pipeline.
// Depends on rhc_pkg and rhc_div_pipe.
//
// Usage:
//   Input channel (in_valid / in_stall) carries operation, chan_a..chan_c and
//   new_saturation. Operation 0 converts RGB to HSV, 1 converts HSV to RGB,
//   2 replaces the saturation of an RGB color; code 3 returns zeros.
//   Output channel (out_valid / out_stall) carries res_a..res_c, one result
//   per input transfer, in order.
//   out_valid rises once the result has passed every stage register (later if
//   the output stalls), the same for every operation.
//   Throughput is one item per cycle while out_stall is low: every stage, including the
//   four stages of the shared-shape divider pipelines (two quotient bits per
//   stage), accepts a new item each cycle unless a stall holds it.
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls, the output register holds its result and bubbles
//   ahead of it still collapse; in_stall rises only once every stage is full.
module rgb_hsv_color_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] chan_a,
	input  logic [7:0] chan_b,
	input  logic [7:0] chan_c,
	input  logic [7:0] new_saturation,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] res_a,
	output logic [7:0] res_b,
	output logic [7:0] res_c
);

	localparam int DEPTH = rhc_pkg::PIPE_DEPTH;

	typedef struct packed {
		logic [1:0]     op;
		rhc_pkg::color_t col;
		rhc_pkg::chan_t ns;
		rhc_pkg::chan_t mx;
		logic           grey;
		rhc_pkg::chan_t base;
		logic           neg;
	} side_t;

	// ---------------- flow control ----------------
	logic [DEPTH:1]   vld_q;
	logic [DEPTH+1:1] rdy;

	always_comb begin
		rdy[DEPTH+1] = !out_stall;
		for (int k = DEPTH; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= DEPTH; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[DEPTH];

	// ---------------- stage 1: extremes, sector, dividends ----------------
	rhc_pkg::chan_t mx, mn, mag, base;
	logic           neg;

	always_comb begin
		mx = chan_a;
		mn = chan_a;
		if (chan_b > mx) mx = chan_b;
		if (chan_c > mx) mx = chan_c;
		if (chan_b < mn) mn = chan_b;
		if (chan_c < mn) mn = chan_c;
		priority if (mx == chan_a) begin
			base = '0;
			neg  = chan_c > chan_b;
			mag  = neg ? chan_c - chan_b : chan_b - chan_c;
		end else if (mx == chan_b) begin
			base = rhc_pkg::HUE_BASE_G;
			neg  = chan_a > chan_c;
			mag  = neg ? chan_a - chan_c : chan_c - chan_a;
		end else begin
			base = rhc_pkg::HUE_BASE_B;
			neg  = chan_b > chan_a;
			mag  = neg ? chan_b - chan_a : chan_a - chan_b;
		end
	end

	side_t          side_s1;
	rhc_pkg::chan_t delta_s1;
	logic [15:0]    num_s_s1;
	logic [15:0]    num_h_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			side_s1.op   <= operation;
			side_s1.col  <= '{a: chan_a, b: chan_b, c: chan_c};
			side_s1.ns   <= new_saturation;
			side_s1.mx   <= mx;
			side_s1.grey <= (mx == mn);
			side_s1.base <= base;
			side_s1.neg  <= neg;
			delta_s1     <= mx - mn;
			// 255 * delta and 43 * |diff|
			num_s_s1     <= {mx - mn, 8'd0} - {8'd0, mx - mn};
			num_h_s1     <= 16'(mag) * 16'(rhc_pkg::HUE_SECTOR);
		end
	end

	// ---------------- stages 2..5: saturation and hue dividers ----------------
	logic [rhc_pkg::DIV_STAGES-1:0] div_adv;
	rhc_pkg::chan_t                 q_sat, q_hue;

	assign div_adv = rdy[rhc_pkg::DIV_STAGES+1:2];

	rhc_div_pipe #(.STEP_BITS(rhc_pkg::DIV_STEP)) u_div_sat (
		.clk (clk),
		.adv (div_adv),
		.num (num_s_s1),
		.den (side_s1.mx),
		.quo (q_sat)
	);

	rhc_div_pipe #(.STEP_BITS(rhc_pkg::DIV_STEP)) u_div_hue (
		.clk (clk),
		.adv (div_adv),
		.num (num_h_s1),
		.den (delta_s1),
		.quo (q_hue)
	);

	side_t side_s2, side_s3, side_s4, side_s5;

	always_ff @(posedge clk) begin
		if (rdy[2]) side_s2 <= side_s1;
		if (rdy[3]) side_s3 <= side_s2;
		if (rdy[4]) side_s4 <= side_s3;
		if (rdy[5]) side_s5 <= side_s4;
	end

	// ---------------- stage 6: finish HSV, pick the color to convert back ----------------
	rhc_pkg::color_t hsv, cv;
	rhc_pkg::chan_t  hue;

	always_comb begin
		hue = side_s5.neg ? side_s5.base - q_hue : side_s5.base + q_hue;
		// black and grey have no hue or saturation
		hsv.a = side_s5.grey ? '0 : hue;
		hsv.b = side_s5.grey ? '0 : q_sat;
		hsv.c = side_s5.mx;
		cv    = hsv;
		if (side_s5.op == rhc_pkg::OP_TO_RGB) begin
			cv = side_s5.col;
		end else if (side_s5.op == rhc_pkg::OP_SET_SAT) begin
			cv.b = side_s5.ns;
		end
	end

	logic [1:0]      op_s6;
	rhc_pkg::color_t hsv_s6, cv_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			op_s6  <= side_s5.op;
			hsv_s6 <= hsv;
			cv_s6  <= cv;
		end
	end

	// ---------------- stage 7: region, remainder, first products ----------------
	logic [2:0]     region;
	rhc_pkg::chan_t offs, rem;
	logic [15:0]    prod_p, prod_sr, prod_st;

	always_comb begin
		priority if (cv_s6.a >= 8'd215) region = 3'd5;
		else if (cv_s6.a >= 8'd172)     region = 3'd4;
		else if (cv_s6.a >= 8'd129)     region = 3'd3;
		else if (cv_s6.a >= 8'd86)      region = 3'd2;
		else if (cv_s6.a >= 8'd43)      region = 3'd1;
		else                            region = 3'd0;
		offs    = 8'(region * rhc_pkg::HUE_SECTOR);
		rem     = 8'(11'(cv_s6.a - offs) * 11'd6);
		prod_p  = 16'(cv_s6.c) * {8'd0, ~cv_s6.b};
		prod_sr = 16'(cv_s6.b) * 16'(rem);
		prod_st = 16'(cv_s6.b) * {8'd0, ~rem};
	end

	logic [1:0]      op_s7;
	rhc_pkg::color_t hsv_s7;
	logic [2:0]      region_s7;
	rhc_pkg::chan_t  v_s7, p_s7, sr_s7, st_s7;
	logic            szero_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			op_s7     <= op_s6;
			hsv_s7    <= hsv_s6;
			region_s7 <= region;
			v_s7      <= cv_s6.c;
			szero_s7  <= (cv_s6.b == '0);
			p_s7      <= prod_p[15:8];
			sr_s7     <= prod_sr[15:8];
			st_s7     <= prod_st[15:8];
		end
	end

	// ---------------- stage 8: q and t ----------------
	logic [15:0] prod_q, prod_t;

	assign prod_q = 16'(v_s7) * {8'd0, ~sr_s7};
	assign prod_t = 16'(v_s7) * {8'd0, ~st_s7};

	logic [1:0]      op_s8;
	rhc_pkg::color_t hsv_s8;
	logic [2:0]      region_s8;
	rhc_pkg::chan_t  v_s8, p_s8, q_s8, t_s8;
	logic            szero_s8;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			op_s8     <= op_s7;
			hsv_s8    <= hsv_s7;
			region_s8 <= region_s7;
			v_s8      <= v_s7;
			szero_s8  <= szero_s7;
			p_s8      <= p_s7;
			q_s8      <= prod_q[15:8];
			t_s8      <= prod_t[15:8];
		end
	end

	// ---------------- stage 9: output register ----------------
	rhc_pkg::color_t rgb, res;

	always_comb begin
		unique case (region_s8)
			3'd0:    rgb = '{a: v_s8, b: t_s8, c: p_s8};
			3'd1:    rgb = '{a: q_s8, b: v_s8, c: p_s8};
			3'd2:    rgb = '{a: p_s8, b: v_s8, c: t_s8};
			3'd3:    rgb = '{a: p_s8, b: q_s8, c: v_s8};
			3'd4:    rgb = '{a: t_s8, b: p_s8, c: v_s8};
			default: rgb = '{a: v_s8, b: p_s8, c: q_s8};
		endcase
		if (szero_s8) begin
			rgb = '{a: v_s8, b: v_s8, c: v_s8};
		end
		unique case (op_s8)
			rhc_pkg::OP_TO_HSV:  res = hsv_s8;
			rhc_pkg::OP_TO_RGB:  res = rgb;
			rhc_pkg::OP_SET_SAT: res = rgb;
			default:             res = '0;
		endcase
	end

	rhc_pkg::color_t res_s9;

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			res_s9 <= res;
		end
	end

	assign res_a = res_s9.a;
	assign res_b = res_s9.b;
	assign res_c = res_s9.c;

endmodule

// ===== rtl/core/rhc_checker.sv =====
// Port-level checker for the RGB/HSV converter, bound to its top level.
// Depends on rhc_pkg for the pipeline depth.
module rhc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] res_a,
	input logic [7:0] res_b,
	input logic [7:0] res_c
);

	localparam int DEPTH = rhc_pkg::PIPE_DEPTH;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Input transfer history and run of cycles without an output stall
	logic [DEPTH-1:0] hist_q;
	logic [CNT_W-1:0] clean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			clean_q <= '0;
		end else begin
			hist_q <= {hist_q[DEPTH-2:0], in_valid && !in_stall};
			if (out_stall) begin
				clean_q <= '0;
			end else if (clean_q != CNT_W'(DEPTH)) begin
				clean_q <= clean_q + CNT_W'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_a) && $stable(res_b)
			&& $stable(res_c))
		else $error("stalled result changed or vanished");

	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while the output flows");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		clean_q == CNT_W'(DEPTH) |-> out_valid == hist_q[DEPTH-1])
		else $error("result does not follow its transfer by the pipeline depth");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind rgb_hsv_color_converter_unit rhc_checker u_rhc_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for rgb_hsv_color_converter_unit.
// Predicts every conversion from its own integer color math and checks results in order.
// Depends on rhc_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         HUE_SPAN    = 43;
	localparam int         BASE_GREEN  = 85;
	localparam int         BASE_BLUE   = 171;
	localparam int         CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = rhc_pkg::OP_TO_HSV;
	logic [7:0] chan_a = '0;
	logic [7:0] chan_b = '0;
	logic [7:0] chan_c = '0;
	logic [7:0] new_saturation = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] res_a;
	logic [7:0] res_b;
	logic [7:0] res_c;

	rhc_pkg::color_t pending_colors[$];
	rhc_pkg::color_t oldest_color;
	int     errors = 0;
	int     cycle_cnt = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     hold_req_cycles = 0;
	int     hold_left = 0;

	rgb_hsv_color_converter_unit i_dut (.*);

	always #2 clk = ~clk;

	function automatic rhc_pkg::color_t rgb_to_hsv(rhc_pkg::chan_t red, rhc_pkg::chan_t green,
			rhc_pkg::chan_t blue);
		int r, g, b, mx, mn, delta, diff, base, hue, sat;
		rhc_pkg::color_t hsv;
		r = red;
		g = green;
		b = blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		hsv = '{a: 8'd0, b: 8'd0, c: rhc_pkg::chan_t'(mx)};
		if (mx == 0)
			return hsv;
		sat = 255 * (mx - mn) / mx;
		hsv.b = rhc_pkg::chan_t'(sat);
		if (sat == 0 || mx == mn)
			return hsv;
		delta = mx - mn;
		if (mx == r) begin
			base = 0;
			diff = g - b;
		end else if (mx == g) begin
			base = BASE_GREEN;
			diff = b - r;
		end else begin
			base = BASE_BLUE;
			diff = r - g;
		end
		// signed division truncates toward zero; a negative hue wraps to 8 bits
		hue = base + (HUE_SPAN * diff) / delta;
		hsv.a = rhc_pkg::chan_t'(hue);
		return hsv;
	endfunction

	function automatic rhc_pkg::color_t hsv_to_rgb(rhc_pkg::chan_t hue, rhc_pkg::chan_t sat,
			rhc_pkg::chan_t val);
		int h, s, v, region, rem, p, q, t;
		rhc_pkg::color_t rgb;
		h = hue;
		s = sat;
		v = val;
		if (s == 0)
			return '{a: val, b: val, c: val};
		region = h / HUE_SPAN;
		rem = ((h - region * HUE_SPAN) * 6) & 255;
		p = (v * (255 - s)) >> 8;
		q = (v * (255 - ((s * rem) >> 8))) >> 8;
		t = (v * (255 - ((s * (255 - rem)) >> 8))) >> 8;
		case (region)
			0: rgb = '{a: val, b: rhc_pkg::chan_t'(t), c: rhc_pkg::chan_t'(p)};
			1: rgb = '{a: rhc_pkg::chan_t'(q), b: val, c: rhc_pkg::chan_t'(p)};
			2: rgb = '{a: rhc_pkg::chan_t'(p), b: val, c: rhc_pkg::chan_t'(t)};
			3: rgb = '{a: rhc_pkg::chan_t'(p), b: rhc_pkg::chan_t'(q), c: val};
			4: rgb = '{a: rhc_pkg::chan_t'(t), b: rhc_pkg::chan_t'(p), c: val};
			// hues past the last full sector land here too
			default: rgb = '{a: val, b: rhc_pkg::chan_t'(p), c: rhc_pkg::chan_t'(q)};
		endcase
		return rgb;
	endfunction

	function automatic rhc_pkg::color_t predict_color(logic [1:0] op, rhc_pkg::chan_t a,
			rhc_pkg::chan_t b, rhc_pkg::chan_t c, rhc_pkg::chan_t ns);
		rhc_pkg::color_t hsv;
		case (op)
			rhc_pkg::OP_TO_HSV: return rgb_to_hsv(a, b, c);
			rhc_pkg::OP_TO_RGB: return hsv_to_rgb(a, b, c);
			rhc_pkg::OP_SET_SAT: begin
				hsv = rgb_to_hsv(a, b, c);
				return hsv_to_rgb(hsv.a, ns, hsv.c);
			end
			default: return '0;
		endcase
	endfunction

	function automatic rhc_pkg::chan_t rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return rhc_pkg::chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void check_chan(string name, rhc_pkg::chan_t want, rhc_pkg::chan_t got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Send one color; wait out random idle cycles, then hold until the transfer.
	task automatic send_color(logic [1:0] op, rhc_pkg::chan_t a, rhc_pkg::chan_t b,
			rhc_pkg::chan_t c, rhc_pkg::chan_t ns);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		chan_a <= a;
		chan_b <= b;
		chan_c <= c;
		new_saturation <= ns;
		do @(posedge clk); while (in_stall);
		pending_colors.push_back(predict_color(op, a, b, c, ns));
		@(negedge clk);
	endtask

	task automatic send_random_color();
		logic [1:0]     op;
		rhc_pkg::chan_t a, b, c, ns;
		int             pick;
		pick = $urandom_range(0, 15);
		if (pick < 5)
			op = rhc_pkg::OP_TO_HSV;
		else if (pick < 10)
			op = rhc_pkg::OP_TO_RGB;
		else if (pick < 15)
			op = rhc_pkg::OP_SET_SAT;
		else
			op = OP_UNUSED;
		a = rand_chan();
		b = rand_chan();
		c = rand_chan();
		ns = rand_chan();
		// grey colors take a path of their own
		if ($urandom_range(0, 9) == 0) begin
			b = a;
			c = a;
		end
		send_color(op, a, b, c, ns);
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_color(rhc_pkg::OP_TO_HSV, 8'd0, 8'd0, 8'd0, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd255, 8'd255, 8'd255, 8'd255);
		send_color(rhc_pkg::OP_TO_HSV, 8'd128, 8'd128, 8'd128, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd255, 8'd0, 8'd0, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd0, 8'd255, 8'd0, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd0, 8'd0, 8'd255, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd255, 8'd0, 8'd10, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd0, 8'd10, 8'd255, 8'd0);
		send_color(rhc_pkg::OP_TO_HSV, 8'd1, 8'd0, 8'd0, 8'd0);
		send_color(rhc_pkg::OP_TO_RGB, 8'd0, 8'd0, 8'd200, 8'd0);
		send_color(rhc_pkg::OP_TO_RGB, 8'd0, 8'd255, 8'd255, 8'd0);
		send_color(rhc_pkg::OP_TO_RGB, 8'd42, 8'd255, 8'd255, 8'd0);
		send_color(rhc_pkg::OP_TO_RGB, 8'd43, 8'd255, 8'd255, 8'd0);
		send_color(rhc_pkg::OP_TO_RGB, 8'd215, 8'd255, 8'd255, 8'd0);
		send_color(rhc_pkg::OP_TO_RGB, 8'd255, 8'd255, 8'd255, 8'd255);
		send_color(rhc_pkg::OP_TO_RGB, 8'd128, 8'd128, 8'd0, 8'd0);
		send_color(rhc_pkg::OP_SET_SAT, 8'd255, 8'd0, 8'd0, 8'd0);
		send_color(rhc_pkg::OP_SET_SAT, 8'd200, 8'd100, 8'd50, 8'd255);
		send_color(rhc_pkg::OP_SET_SAT, 8'd0, 8'd0, 8'd0, 8'd255);
		send_color(rhc_pkg::OP_SET_SAT, 8'd90, 8'd90, 8'd90, 8'd200);
		send_color(rhc_pkg::OP_SET_SAT, 8'd255, 8'd0, 8'd10, 8'd128);
		send_color(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
		send_color(OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	task automatic test_random_traffic(int count, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_random_color();
	endtask

	// Hold the output for a long stretch while colors keep coming, so the pipe fills.
	task automatic test_output_hold_fills_pipe();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req_cycles = 80;
		repeat (40) send_random_color();
	endtask

	always @(negedge clk) begin
		if (hold_req_cycles > 0) begin
			hold_left = hold_req_cycles;
			hold_req_cycles = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_colors.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h %h %h",
					$time, res_a, res_b, res_c);
			end else begin
				oldest_color = pending_colors.pop_front();
				check_chan("res_a", oldest_color.a, res_a);
				check_chan("res_b", oldest_color.b, res_b);
				check_chan("res_c", oldest_color.c, res_c);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_traffic(420, 7, 85);
		test_random_traffic(420, 85, 7);
		test_random_traffic(420, 0, 0);
		test_output_hold_fills_pipe();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (2 * rhc_pkg::PIPE_DEPTH) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rhc_pkg.sv
rtl/core/rhc_div_pipe.sv
rtl/core/rgb_hsv_color_converter_unit.sv
rtl/core/rhc_checker.sv
tb/tb_top.sv
